>>> sv/txtmp_pkg.sv
// Package for the text matrix parser: character codes, phase encoding and
// the result record that travels from the parser core to the output queue.
// No dependencies.
`timescale 1ns / 1ps

package txtmp_pkg;

    localparam int DIM_WIDTH_DEFAULT = 16;
    localparam int VALUE_W           = 31;
    localparam int POS_W             = 16;
    localparam int ERR_W             = 16;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [ERR_W-1:0]   ERR_MAX   = '1;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [6:0] {
        PH_SEEK_ROWS = 7'b0000001,
        PH_SKIP_ROWS = 7'b0000010,
        PH_READ_ROWS = 7'b0000100,
        PH_SEEK_COLS = 7'b0001000,
        PH_SKIP_COLS = 7'b0010000,
        PH_READ_COLS = 7'b0100000,
        PH_BODY      = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               out_of_range;
        logic [POS_W-1:0]   rows;
        logic [POS_W-1:0]   cols;
        logic [ERR_W-1:0]   error_count;
        logic               matrix_ok;
        logic               last;
    } result_t;

    typedef struct packed {
        logic first_valid;
        logic second_valid;
    } push_ctl_t;

endpackage

>>> sv/txtmp_byte_if.sv
// Input channel of the text matrix parser: one file character per transaction.
// No dependencies.
`timescale 1ns / 1ps

interface txtmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

>>> sv/txtmp_result_if.sv
// Output channel of the text matrix parser: one element or status record per
// transaction. No dependencies.
`timescale 1ns / 1ps

interface txtmp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [30:0] value;
    logic        out_of_range;
    logic [15:0] rows;
    logic [15:0] cols;
    logic [15:0] error_count;
    logic        matrix_ok;
    logic        last;

    modport source (output valid, output kind, output row, output col, output value,
                    output out_of_range, output rows, output cols, output error_count,
                    output matrix_ok, output last, input ready);
    modport sink   (input valid, input kind, input row, input col, input value,
                    input out_of_range, input rows, input cols, input error_count,
                    input matrix_ok, input last, output ready);
endinterface

>>> sv/txtmp_core.sv
// Parser core: header and body state machine, token accumulator and
// position counters. Produces up to two result records per accepted byte.
// Depends on txtmp_pkg.
`timescale 1ns / 1ps

module txtmp_core #(
    parameter int DIM_WIDTH = txtmp_pkg::DIM_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_input,
    output txtmp_pkg::result_t    first_res,
    output txtmp_pkg::result_t    second_res,
    output txtmp_pkg::push_ctl_t  push
);

    localparam int ACC_W = (DIM_WIDTH > txtmp_pkg::VALUE_W) ? DIM_WIDTH : txtmp_pkg::VALUE_W;
    localparam int MUL_W = ACC_W + 4;
    localparam int EXT_W = (DIM_WIDTH > txtmp_pkg::POS_W) ? DIM_WIDTH : txtmp_pkg::POS_W;
    localparam logic [DIM_WIDTH-1:0] DIM_MAX = '1;

    txtmp_pkg::phase_t              phase_reg, phase_next;
    logic [ACC_W-1:0]               acc_reg, acc_next;
    logic                           pending_reg, pending_next;
    logic                           hdr_stop_reg, hdr_stop_next;
    logic [DIM_WIDTH-1:0]           row_idx_reg, row_idx_next;
    logic [DIM_WIDTH-1:0]           col_idx_reg, col_idx_next;
    logic [DIM_WIDTH-1:0]           row_cnt_reg, row_cnt_next;
    logic [DIM_WIDTH-1:0]           col_cnt_reg, col_cnt_next;
    logic [txtmp_pkg::ERR_W-1:0]    err_reg, err_next;

    logic                           is_digit;
    logic [MUL_W-1:0]               prod;
    logic [ACC_W-1:0]               hdr_acc;
    logic [ACC_W-1:0]               body_acc;
    logic [txtmp_pkg::ERR_W-1:0]    err_inc;
    logic [DIM_WIDTH-1:0]           row_inc;
    logic [DIM_WIDTH-1:0]           col_inc;
    logic [DIM_WIDTH-1:0]           end_row;
    logic [DIM_WIDTH-1:0]           end_col;
    txtmp_pkg::result_t             base_res;
    txtmp_pkg::result_t             status_res;

    function automatic logic [txtmp_pkg::POS_W-1:0] to_pos(input logic [DIM_WIDTH-1:0] x);
        logic [EXT_W-1:0] e;
        e = EXT_W'(x);
        return e[txtmp_pkg::POS_W-1:0];
    endfunction

    // Running digit update, saturated separately for header counts and tokens.
    assign is_digit = (data_byte >= txtmp_pkg::CHAR_0) && (data_byte <= txtmp_pkg::CHAR_9);
    assign prod     = MUL_W'(acc_reg) * MUL_W'(txtmp_pkg::DECIMAL_BASE)
                    + MUL_W'(data_byte - txtmp_pkg::CHAR_0);
    assign hdr_acc  = (prod > MUL_W'(DIM_MAX)) ? ACC_W'(DIM_MAX) : ACC_W'(prod);
    assign body_acc = (prod > MUL_W'(txtmp_pkg::VALUE_MAX)) ?
                      ACC_W'(txtmp_pkg::VALUE_MAX) : ACC_W'(prod);
    assign err_inc  = (err_reg == txtmp_pkg::ERR_MAX) ? err_reg : err_reg + 1'b1;
    assign row_inc  = (row_idx_reg == DIM_MAX) ? row_idx_reg : row_idx_reg + 1'b1;
    assign col_inc  = (col_idx_reg == DIM_MAX) ? col_idx_reg : col_idx_reg + 1'b1;
    assign end_row  = row_cnt_reg - 1'b1;
    assign end_col  = col_cnt_reg - 1'b1;

    always_comb
    begin
        base_res              = '0;
        base_res.rows         = to_pos(row_cnt_reg);
        base_res.cols         = to_pos(col_cnt_reg);
        base_res.error_count  = err_reg;
        base_res.value        = acc_reg[txtmp_pkg::VALUE_W-1:0];
        status_res            = base_res;
        status_res.value      = '0;
        status_res.kind       = txtmp_pkg::KIND_STATUS;
        status_res.matrix_ok  = (err_reg == '0);
        status_res.last       = 1'b1;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        pending_next  = pending_reg;
        hdr_stop_next = hdr_stop_reg;
        row_idx_next  = row_idx_reg;
        col_idx_next  = col_idx_reg;
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        err_next      = err_reg;
        first_res     = base_res;
        second_res    = status_res;
        push          = '0;

        if (accept)
        begin
            if (end_of_input)
            begin
                if ((phase_reg == txtmp_pkg::PH_BODY) && pending_reg)
                begin
                    // The pending token lands on the last header position.
                    first_res.row          = to_pos(end_row);
                    first_res.col          = to_pos(end_col);
                    first_res.out_of_range = (end_row >= row_cnt_reg) ||
                                             (end_col >= col_cnt_reg);
                    push.first_valid       = 1'b1;
                    push.second_valid      = 1'b1;
                end
                else
                begin
                    first_res        = status_res;
                    push.first_valid = 1'b1;
                end
                phase_next    = txtmp_pkg::PH_SEEK_ROWS;
                acc_next      = '0;
                pending_next  = 1'b0;
                hdr_stop_next = 1'b0;
                row_idx_next  = '0;
                col_idx_next  = '0;
                row_cnt_next  = '0;
                col_cnt_next  = '0;
                err_next      = '0;
            end
            else
            begin
                unique case (phase_reg)
                    txtmp_pkg::PH_SEEK_ROWS:
                    begin
                        if (data_byte == txtmp_pkg::CHAR_EQ)
                            phase_next = txtmp_pkg::PH_SKIP_ROWS;
                    end
                    txtmp_pkg::PH_SEEK_COLS:
                    begin
                        if (data_byte == txtmp_pkg::CHAR_EQ)
                            phase_next = txtmp_pkg::PH_SKIP_COLS;
                    end
                    txtmp_pkg::PH_SKIP_ROWS:
                    begin
                        phase_next    = txtmp_pkg::PH_READ_ROWS;
                        acc_next      = '0;
                        hdr_stop_next = 1'b0;
                    end
                    txtmp_pkg::PH_SKIP_COLS:
                    begin
                        phase_next    = txtmp_pkg::PH_READ_COLS;
                        acc_next      = '0;
                        hdr_stop_next = 1'b0;
                    end
                    txtmp_pkg::PH_READ_ROWS, txtmp_pkg::PH_READ_COLS:
                    begin
                        if (data_byte == txtmp_pkg::CHAR_NL)
                        begin
                            if (phase_reg == txtmp_pkg::PH_READ_ROWS)
                            begin
                                row_cnt_next = acc_reg[DIM_WIDTH-1:0];
                                phase_next   = txtmp_pkg::PH_SEEK_COLS;
                            end
                            else
                            begin
                                col_cnt_next = acc_reg[DIM_WIDTH-1:0];
                                phase_next   = txtmp_pkg::PH_BODY;
                            end
                            acc_next      = '0;
                            hdr_stop_next = 1'b0;
                        end
                        else if (is_digit && !hdr_stop_reg)
                            acc_next = hdr_acc;
                        else
                            hdr_stop_next = 1'b1;
                    end
                    txtmp_pkg::PH_BODY:
                    begin
                        if (is_digit)
                        begin
                            acc_next     = body_acc;
                            pending_next = 1'b1;
                        end
                        else if ((data_byte == txtmp_pkg::CHAR_SP) ||
                                 (data_byte == txtmp_pkg::CHAR_NL))
                        begin
                            if (pending_reg)
                            begin
                                first_res.row          = to_pos(row_idx_reg);
                                first_res.col          = to_pos(col_idx_reg);
                                first_res.out_of_range = (row_idx_reg >= row_cnt_reg) ||
                                                         (col_idx_reg >= col_cnt_reg);
                                first_res.last         = 1'b1;
                                push.first_valid       = 1'b1;
                                acc_next               = '0;
                                pending_next           = 1'b0;
                                if (data_byte == txtmp_pkg::CHAR_SP)
                                    col_idx_next = col_inc;
                                else
                                begin
                                    row_idx_next = row_inc;
                                    col_idx_next = '0;
                                end
                            end
                            else
                                err_next = err_inc;
                        end
                        else
                            err_next = err_inc;
                    end
                    default:
                    begin
                        phase_next = txtmp_pkg::PH_SEEK_ROWS;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= txtmp_pkg::PH_SEEK_ROWS;
            acc_reg      <= '0;
            pending_reg  <= 1'b0;
            hdr_stop_reg <= 1'b0;
            row_idx_reg  <= '0;
            col_idx_reg  <= '0;
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            err_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            pending_reg  <= pending_next;
            hdr_stop_reg <= hdr_stop_next;
            row_idx_reg  <= row_idx_next;
            col_idx_reg  <= col_idx_next;
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            err_reg      <= err_next;
        end
    end

    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=> (phase_reg == txtmp_pkg::PH_SEEK_ROWS) &&
                                     (acc_reg == '0) && !pending_reg && (err_reg == '0))
        else $error("parser did not return to its initial state after end of input");

    a_pending_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (phase_reg == txtmp_pkg::PH_BODY))
        else $error("token pending outside the matrix body");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second_valid |-> (push.first_valid && accept && end_of_input))
        else $error("second result pushed without a first one or outside end of input");

endmodule

>>> sv/txtmp_res_fifo.sv
// Output queue of the text matrix parser: four result records, up to two
// written per cycle, one read per cycle. Depends on txtmp_pkg.
`timescale 1ns / 1ps

module txtmp_res_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  txtmp_pkg::push_ctl_t  push,
    input  txtmp_pkg::result_t    first_res,
    input  txtmp_pkg::result_t    second_res,
    output logic                  room,
    output logic                  head_valid,
    input  logic                  head_ready,
    output txtmp_pkg::result_t    head
);

    localparam int PW = txtmp_pkg::FIFO_PTR_W;

    txtmp_pkg::result_t  mem_reg [txtmp_pkg::FIFO_DEPTH];
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW:0]         count_reg, count_next;
    logic [PW-1:0]       wr_ptr_plus1;
    logic                pop;
    logic [1:0]          push_n;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign head_valid   = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign pop          = head_valid && head_ready;
    assign push_n       = 2'(push.first_valid) + 2'(push.second_valid);
    // Room for a full pair of results is needed before a byte is taken.
    assign room         = (count_reg <= (PW+1)'(txtmp_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        count_next  = count_reg + (PW+1)'(push_n) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            mem_reg[wr_ptr_reg] <= first_res;
        if (push.second_valid)
            mem_reg[wr_ptr_plus1] <= second_res;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(txtmp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.first_valid || push.second_valid) |-> room)
        else $error("result pushed while the queue lacked room for a pair");

endmodule

>>> sv/text_matrix_parser.sv
// Text matrix parser, top level: byte stream in, element and status records out.
// Results: each record is written into the result queue when its byte is taken.
// Throughput: one byte per cycle; a byte is taken while the four-entry result
// queue has room for two records, which it always has when the sink keeps up.
// Reset: rst_n clears the parser and the queue at once; no clearing pass.
// Depends on txtmp_pkg, txtmp_byte_if, txtmp_result_if, txtmp_core, txtmp_res_fifo.
`timescale 1ns / 1ps

module text_matrix_parser #(
    parameter int DIM_WIDTH = txtmp_pkg::DIM_WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    txtmp_byte_if.sink      byte_stream,
    txtmp_result_if.source  result_stream
);

    // A transaction on the byte channel is taken whenever the queue can absorb
    // the largest burst one byte can cause: an element plus the status record
    // at end of input.
    logic                  room;
    logic                  accept;
    txtmp_pkg::result_t    first_res;
    txtmp_pkg::result_t    second_res;
    txtmp_pkg::push_ctl_t  push;
    txtmp_pkg::result_t    head;

    assign byte_stream.ready = room;
    assign accept            = byte_stream.valid && room;

    // The core does all parsing in a single pass per byte; its state registers
    // hold the header phase, token accumulator, counters and error count.
    txtmp_core #(
        .DIM_WIDTH (DIM_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (byte_stream.data_byte),
        .end_of_input (byte_stream.end_of_input),
        .first_res    (first_res),
        .second_res   (second_res),
        .push         (push)
    );

    // The result queue decouples the sink: a stalled output transaction never
    // blocks the byte stream until the queue is nearly full.
    txtmp_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .first_res  (first_res),
        .second_res (second_res),
        .room       (room),
        .head_valid (result_stream.valid),
        .head_ready (result_stream.ready),
        .head       (head)
    );

    // Unpack the queue head onto the output channel.
    assign result_stream.kind         = head.kind;
    assign result_stream.row          = head.row;
    assign result_stream.col          = head.col;
    assign result_stream.value        = head.value;
    assign result_stream.out_of_range = head.out_of_range;
    assign result_stream.rows         = head.rows;
    assign result_stream.cols         = head.cols;
    assign result_stream.error_count  = head.error_count;
    assign result_stream.matrix_ok    = head.matrix_ok;
    assign result_stream.last         = head.last;

endmodule

>>> dv/txtmp_tb_pkg.sv
// Scoreboard for the text matrix parser testbench: a cycle-free model of the
// parser that predicts the records each accepted byte causes, and the checker
// that compares delivered records against them. Depends on txtmp_pkg.
`timescale 1ns / 1ps

package txtmp_tb_pkg;

    import txtmp_pkg::*;

    // Header counts saturate at the all-ones value of the default dimension width.
    localparam logic [63:0] DIM_LIMIT   = (64'd1 << DIM_WIDTH_DEFAULT) - 64'd1;
    localparam logic [63:0] VALUE_LIMIT = 64'(VALUE_MAX);
    localparam int          REPORT_MAX  = 10;

    class matrix_record_board;

        phase_t           phase;
        logic [63:0]      acc;
        bit               token_open;
        bit               header_stop;
        logic [POS_W-1:0] row_idx;
        logic [POS_W-1:0] col_idx;
        logic [POS_W-1:0] row_cnt;
        logic [POS_W-1:0] col_cnt;
        logic [ERR_W-1:0] errs;
        result_t          awaited[$];
        int               mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        // State after reset, and again after every end of file.
        function void restart();
            phase       = PH_SEEK_ROWS;
            acc         = '0;
            token_open  = 1'b0;
            header_stop = 1'b0;
            row_idx     = '0;
            col_idx     = '0;
            row_cnt     = '0;
            col_cnt     = '0;
            errs        = '0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void count_error();
            if (errs != ERR_MAX)
                errs++;
        endfunction

        // Position indexes stop at all ones; the default width equals the port width.
        function logic [POS_W-1:0] bump_index(logic [POS_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void push_record(logic kind, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                  logic [VALUE_W-1:0] val, logic oor, logic ok,
                                  logic last);
            result_t rec;
            rec.kind         = kind;
            rec.row          = r;
            rec.col          = c;
            rec.value        = val;
            rec.out_of_range = oor;
            rec.rows         = row_cnt;
            rec.cols         = col_cnt;
            rec.error_count  = errs;
            rec.matrix_ok    = ok;
            rec.last         = last;
            awaited.push_back(rec);
        endfunction

        function void push_element(logic [POS_W-1:0] r, logic [POS_W-1:0] c, logic last);
            push_record(KIND_ELEMENT, r, c, acc[VALUE_W-1:0],
                        (r >= row_cnt) || (c >= col_cnt), 1'b0, last);
            acc        = '0;
            token_open = 1'b0;
        endfunction

        // Called once per accepted byte transaction.
        function void take_byte(logic [7:0] b, logic eoi);
            logic        digit;
            logic [63:0] grown;
            digit = (b >= CHAR_0) && (b <= CHAR_9);
            grown = acc * 64'd10 + 64'(b - CHAR_0);
            if (eoi)
            begin
                // A token still open at end of file lands on the last cell.
                if (phase == PH_BODY && token_open)
                    push_element(row_cnt - 1'b1, col_cnt - 1'b1, 1'b0);
                push_record(KIND_STATUS, '0, '0, '0, 1'b0, errs == '0, 1'b1);
                restart();
                return;
            end
            case (phase)
                PH_SEEK_ROWS:
                    if (b == CHAR_EQ)
                        phase = PH_SKIP_ROWS;
                PH_SEEK_COLS:
                    if (b == CHAR_EQ)
                        phase = PH_SKIP_COLS;
                PH_SKIP_ROWS, PH_SKIP_COLS:
                begin
                    phase       = (phase == PH_SKIP_ROWS) ? PH_READ_ROWS : PH_READ_COLS;
                    acc         = '0;
                    header_stop = 1'b0;
                end
                PH_READ_ROWS, PH_READ_COLS:
                begin
                    if (b == CHAR_NL)
                    begin
                        if (phase == PH_READ_ROWS)
                        begin
                            row_cnt = acc[POS_W-1:0];
                            phase   = PH_SEEK_COLS;
                        end
                        else
                        begin
                            col_cnt = acc[POS_W-1:0];
                            phase   = PH_BODY;
                        end
                        acc         = '0;
                        header_stop = 1'b0;
                    end
                    else if (digit && !header_stop)
                        acc = (grown > DIM_LIMIT) ? DIM_LIMIT : grown;
                    else
                        header_stop = 1'b1;
                end
                default:
                begin
                    if (digit)
                    begin
                        acc        = (grown > VALUE_LIMIT) ? VALUE_LIMIT : grown;
                        token_open = 1'b1;
                    end
                    else if ((b == CHAR_SP || b == CHAR_NL) && token_open)
                    begin
                        push_element(row_idx, col_idx, 1'b1);
                        if (b == CHAR_SP)
                            col_idx = bump_index(col_idx);
                        else
                        begin
                            row_idx = bump_index(row_idx);
                            col_idx = '0;
                        end
                    end
                    else
                        count_error();
                end
            endcase
        endfunction

        function string show(result_t r);
            return $sformatf({"kind=%0d row=%0d col=%0d value=%0d oor=%0d rows=%0d ",
                              "cols=%0d errors=%0d ok=%0d last=%0d"},
                             r.kind, r.row, r.col, r.value, r.out_of_range, r.rows,
                             r.cols, r.error_count, r.matrix_ok, r.last);
        endfunction

        // Called once per accepted result transaction.
        function void check_record(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected record: %s", show(got));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
                got.value !== want.value || got.out_of_range !== want.out_of_range ||
                got.rows !== want.rows || got.cols !== want.cols ||
                got.error_count !== want.error_count || got.matrix_ok !== want.matrix_ok ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("record mismatch, expected: %s", show(want));
                    $display("                 actual:   %s", show(got));
                end
            end
        endfunction

    endclass

endpackage

>>> dv/tb_top.sv
// Top-level testbench of the text matrix parser: directed and random text
// files go in byte by byte, every element and status record is checked.
// Depends on txtmp_pkg, txtmp_byte_if, txtmp_result_if, txtmp_tb_pkg, text_matrix_parser.
`timescale 1ns / 1ps

module tb_top;

    import txtmp_pkg::*;
    import txtmp_tb_pkg::*;

    // Watchdog limit; a correct run ends far below it.
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    // Tokens in the file that streams in while the receiver holds off.
    localparam int HOLD_TOKENS  = 8;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_EVERY_THIRD,
        SINK_RARE_STALL
    } sink_mode_t;

    logic clk;
    logic rst_n;

    txtmp_byte_if   byte_if ();
    txtmp_result_if res_if ();

    text_matrix_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_if),
        .result_stream (res_if)
    );

    matrix_record_board records = new();

    int         bytes_sent    = 0;
    int         burst_left    = 0;
    bit         steady_source = 1'b0;  // sender offers a byte every cycle while set
    bit         hold_request  = 1'b0;  // asks the receiver for one long hold-off
    longint     cycle_count   = 0;
    logic [7:0] header_bytes[$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one byte transaction and waits until the parser takes it. The
    // sender works in bursts; a gap is only inserted when a burst runs out, so
    // valid is never dropped and raised again within one time step.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        if (!steady_source)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(0, 6);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 16);
                if (gap > 0)
                begin
                    byte_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        byte_if.valid        <= 1'b1;
        byte_if.data_byte    <= b;
        byte_if.end_of_input <= eoi;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        records.take_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_item(txt[i], 1'b0);
    endtask

    // End of file; the data byte is a don't-care, so it is random.
    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_number(input longint unsigned v);
        send_text($sformatf("%0d", v));
    endtask

    // Header counts are mostly small so that bodies stay short; a few are zero
    // and a few overflow the dimension width and saturate.
    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(0, 99999);
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    // Token values: some go well beyond 2^31-1 to hit value saturation.
    function automatic longint unsigned pick_value();
        case ($urandom_range(0, 11))
            0:       return 64'($urandom()) * 64'($urandom_range(1, 5000));
            1:       return $urandom_range(0, 9);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    // Appends one header line: a random label with no equals sign, the equals
    // sign, one skipped character of any value, the count (sometimes missing)
    // and now and then some trailing junk that the parser has to ignore.
    function automatic void add_header_line(input int count);
        int         n;
        string      txt;
        logic [7:0] ch;
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            ch = 8'($urandom_range(0, 255));
            header_bytes.push_back((ch == CHAR_EQ) ? CHAR_SP : ch);
        end
        header_bytes.push_back(CHAR_EQ);
        header_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) != 0)
        begin
            txt = $sformatf("%0d", count);
            for (int i = 0; i < txt.len(); i++)
                header_bytes.push_back(txt[i]);
        end
        if ($urandom_range(0, 5) == 0)
        begin
            ch = 8'($urandom_range(0, 255));
            header_bytes.push_back((ch == CHAR_NL) ? CHAR_SP : ch);
            header_bytes.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
        end
        header_bytes.push_back(CHAR_NL);
    endfunction

    // One mostly well-formed file. Some are cut short inside the header, some
    // write more rows or columns than announced, a few carry stray bytes, and
    // about half end with the last token still open.
    task automatic send_random_file();
        int  rows_hdr;
        int  cols_hdr;
        int  rows_body;
        int  cols_body;
        int  cut;
        bit  leave_open;
        rows_hdr = pick_count();
        cols_hdr = pick_count();
        header_bytes.delete();
        add_header_line(rows_hdr);
        add_header_line(cols_hdr);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, header_bytes.size() - 1)
                                          : header_bytes.size();
        for (int i = 0; i < cut; i++)
            send_item(header_bytes[i], 1'b0);
        if (cut < header_bytes.size())
        begin
            send_end();
            return;
        end
        rows_body  = ((rows_hdr > 4) ? 4 : rows_hdr) + int'($urandom_range(0, 4) == 0);
        cols_body  = ((cols_hdr > 5) ? 5 : cols_hdr) + int'($urandom_range(0, 4) == 0);
        leave_open = 1'($urandom_range(0, 1));
        for (int r = 0; r < rows_body; r++)
        begin
            for (int c = 0; c < cols_body; c++)
            begin
                if ($urandom_range(0, 24) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                send_number(pick_value());
                if (!(leave_open && r == rows_body - 1 && c == cols_body - 1))
                    send_item((c == cols_body - 1) ? CHAR_NL : CHAR_SP, 1'b0);
            end
        end
        send_end();
    endtask

    // Plain noise: random bytes, sometimes closed by an end of file.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 20);
        repeat (n)
            send_item(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 1))
            send_end();
    endtask

    // ------------------------------------------------------------------
    // Receiver side: ready follows a pattern mode, redrawn when its countdown
    // runs out. On request it holds off for HOLD_CYCLES, counted here, so the
    // result queue fills up and the parser has to stall its byte input.
    // ------------------------------------------------------------------
    initial
    begin : sink_pattern
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        int         tick;
        logic       next_ready;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (mode_left == 0)
            begin
                mode      = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            if (hold_request && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else
            begin
                case (mode)
                    SINK_OPEN:        next_ready = 1'b1;
                    SINK_COIN:        next_ready = 1'($urandom_range(0, 1));
                    SINK_EVERY_THIRD: next_ready = (tick % 3) == 0;
                    default:          next_ready = $urandom_range(0, 7) != 0;
                endcase
            end
            res_if.ready <= next_ready;
        end
    end

    // Result monitor: sampled at the clock edge, so the values seen are the
    // ones the parser presented during the cycle that just ended.
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.kind         = res_if.kind;
            got.row          = res_if.row;
            got.col          = res_if.col;
            got.value        = res_if.value;
            got.out_of_range = res_if.out_of_range;
            got.rows         = res_if.rows;
            got.cols         = res_if.cols;
            got.error_count  = res_if.error_count;
            got.matrix_ok    = res_if.matrix_ok;
            got.last         = res_if.last;
            records.check_record(got);
        end
    end

    // Cycle counter that ends a hung run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[text_matrix_parser] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int goal;
        int start;
        bit hold_used;
        hold_used = 1'b0;
        rst_n                <= 1'b0;
        byte_if.valid        <= 1'b0;
        byte_if.data_byte    <= '0;
        byte_if.end_of_input <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An end of file with no header at all gives a clean
        // status. Then a file whose row count stops at a non-digit and whose
        // column count is zero; its body has a saturating value, a 0xFF
        // byte, an empty separator, and a token left open at the end, which
        // lands on the wrapped all-ones column.
        send_end();
        send_text("=:1z\n");
        send_text("==0\n");
        send_text("3000000000\n");
        send_item(8'hFF, 1'b0);
        send_text(" ");
        send_text("4");
        send_end();

        // Random part: mostly well-formed files with random content, the rest
        // noise. Once, early on, the receiver holds off while a dense file
        // streams in without gaps, so the queue fills and the input stalls.
        start = bytes_sent;
        goal  = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < goal)
        begin
            if (!hold_used && bytes_sent >= start + 300)
            begin
                hold_used     = 1'b1;
                hold_request  = 1'b1;
                steady_source = 1'b1;
                send_text("=x2\n=x9\n");
                repeat (HOLD_TOKENS)
                    send_text("5 ");
                send_end();
                steady_source = 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
                send_noise();
            else
                send_random_file();
        end
        byte_if.valid <= 1'b0;

        while (records.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (records.mismatches == 0 && records.outstanding() == 0)
            $display("[text_matrix_parser] OK");
        else
            $display("[text_matrix_parser] ERROR");
        $finish;
    end

endmodule
